// File: rtl/acb_pkg.sv
// Shared types and constants for the accumulator bytecode core.
// Holds command codes, opcodes, status codes, instruction classes and the
// controller/datapath command and status structs. No dependencies.
package acb_pkg;

  localparam logic [2:0] CMD_WRITE   = 3'd0;
  localparam logic [2:0] CMD_READ    = 3'd1;
  localparam logic [2:0] CMD_EXEC    = 3'd2;
  localparam logic [2:0] CMD_INPUT   = 3'd3;
  localparam logic [2:0] CMD_RESTART = 3'd4;

  localparam logic REG_DATA_BASE = 1'b0;
  localparam logic REG_START     = 1'b1;

  localparam logic [5:0] OP_LOAD   = 6'd0;
  localparam logic [5:0] OP_STORE  = 6'd1;
  localparam logic [5:0] OP_LDI    = 6'd2;
  localparam logic [5:0] OP_ADDI   = 6'd3;
  localparam logic [5:0] OP_ADDV   = 6'd4;
  localparam logic [5:0] OP_SUBV   = 6'd5;
  localparam logic [5:0] OP_SUBI   = 6'd6;
  localparam logic [5:0] OP_MULI   = 6'd7;
  localparam logic [5:0] OP_MULV   = 6'd8;
  localparam logic [5:0] OP_DIVV   = 6'd9;
  localparam logic [5:0] OP_DIVI   = 6'd10;
  localparam logic [5:0] OP_CMPII  = 6'd11;
  localparam logic [5:0] OP_CMPVI  = 6'd12;
  localparam logic [5:0] OP_JNE    = 6'd13;
  localparam logic [5:0] OP_ADDM   = 6'd14;
  localparam logic [5:0] OP_ADDM2  = 6'd15;
  localparam logic [5:0] OP_SUBM   = 6'd16;
  localparam logic [5:0] OP_SUBI2  = 6'd17;
  localparam logic [5:0] OP_MULI2  = 6'd18;
  localparam logic [5:0] OP_MULM   = 6'd19;
  localparam logic [5:0] OP_DIVM   = 6'd20;
  localparam logic [5:0] OP_DIVI2  = 6'd21;
  localparam logic [5:0] OP_STORE2 = 6'd22;
  localparam logic [5:0] OP_PRV    = 6'd24;
  localparam logic [5:0] OP_PRS    = 6'd25;
  localparam logic [5:0] OP_TEQ    = 6'd26;
  localparam logic [5:0] OP_CMPAI  = 6'd27;
  localparam logic [5:0] OP_CMPAV  = 6'd28;
  localparam logic [5:0] OP_MOVV   = 6'd29;
  localparam logic [5:0] OP_JMP    = 6'd30;
  localparam logic [5:0] OP_INP    = 6'd31;
  localparam logic [5:0] OP_MOVI   = 6'd32;
  localparam logic [5:0] OP_MOVIND = 6'd33;
  localparam logic [5:0] OP_STIND  = 6'd34;
  localparam logic [5:0] OP_LDI2   = 6'd35;
  localparam logic [5:0] OP_CALL   = 6'd36;
  localparam logic [5:0] OP_RET    = 6'd37;
  localparam logic [5:0] OP_EXIT   = 6'd38;
  localparam logic [5:0] OP_TGT    = 6'd39;
  localparam logic [5:0] OP_TLT    = 6'd40;

  typedef enum logic [3:0] {
    ST_OK, ST_DIVZERO, ST_OVERFLOW, ST_UNDERFLOW, ST_ILLEGAL,
    ST_PRINTVAL, ST_PRINTSTR, ST_INPUTREQ, ST_EXIT, ST_WAITING
  } status_t;

  typedef enum logic [5:0] {
    C_LOAD, C_STORE, C_MOVV, C_MOVI, C_LDI, C_TEQ, C_TGT, C_TLT,
    C_ADDI, C_ADDV, C_SUBV, C_SUBI, C_MULI, C_MULV, C_DIVV, C_DIVI,
    C_ADDM, C_SUBM, C_MULM, C_DIVM, C_CMPII, C_CMPVI, C_CMPAI, C_CMPAV,
    C_JNE, C_JMP, C_MOVIND, C_STIND, C_PRV, C_PRS, C_INP, C_EXIT,
    C_CALL, C_RET, C_ILL
  } cls_t;

  typedef enum logic [3:0] {
    A_IN, A_PC, A_PC1, A_PC2, A_VO1, A_VO2, A_VT, A_TGT, A_SCAN
  } asel_t;

  typedef enum logic [2:0] {W_IN, W_ACC, W_T, W_O2, W_R} wsel_t;
  typedef enum logic [1:0] {X_ACC, X_T, X_O1} xsel_t;
  typedef enum logic [1:0] {Y_O1, Y_O2, Y_T, Y_ACC} ysel_t;
  typedef enum logic [2:0] {OP_ADD, OP_SUB, OP_MUL, OP_PASS, OP_DIV} aluop_t;
  typedef enum logic [1:0] {TR_VO1, TR_PC1} trsel_t;

  typedef enum logic [2:0] {
    PC_ADV1, PC_ADV2, PC_ADV3, PC_JT, PC_START, PC_POP, PC_SCANN, PC_TRAP
  } pcsel_t;

  typedef struct packed {
    logic    in_ld;
    logic    rd_en;
    asel_t   rd_sel;
    logic    wr_en;
    asel_t   wr_sel;
    wsel_t   wd_sel;
    logic    op_ld;
    logic    o1_ld;
    logic    o2_ld;
    logic    t_ld;
    logic    rdata_ld;
    xsel_t   x_sel;
    ysel_t   y_sel;
    aluop_t  alu_op;
    logic    r_ld;
    logic    acc_ld;
    logic    acc_one;
    logic    cmp_ld;
    logic    pc_ld;
    pcsel_t  pc_sel;
    logic    push;
    logic    pop;
    logic    clr_depth;
    logic    pend_set;
    logic    pend_clr;
    logic    tr_ld;
    trsel_t  tr_sel;
    logic    div_start;
    logic    scan_init;
    logic    scan_step;
    logic    res_ld;
    status_t res_status;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    cls_t       cls;
    logic       pend;
    logic       acc_zero;
    logic       o1_zero;
    logic       t_zero;
    logic       eq;
    logic       gt;
    logic       lt;
    logic       stack_full;
    logic       stack_empty;
    logic       div_done;
    logic       mem_zero;
    logic       scan_last;
  } dp_stat_t;

  function automatic cls_t op_class(input logic [31:0] op);
    cls_t c;
    c = C_ILL;
    if (op[31:6] == 26'd0) begin
      case (op[5:0])
        OP_LOAD:              c = C_LOAD;
        OP_STORE, OP_STORE2:  c = C_STORE;
        OP_MOVV:              c = C_MOVV;
        OP_MOVI:              c = C_MOVI;
        OP_LDI, OP_LDI2:      c = C_LDI;
        OP_TEQ:               c = C_TEQ;
        OP_TGT:               c = C_TGT;
        OP_TLT:               c = C_TLT;
        OP_ADDI:              c = C_ADDI;
        OP_ADDV:              c = C_ADDV;
        OP_SUBV:              c = C_SUBV;
        OP_SUBI, OP_SUBI2:    c = C_SUBI;
        OP_MULI, OP_MULI2:    c = C_MULI;
        OP_MULV:              c = C_MULV;
        OP_DIVV:              c = C_DIVV;
        OP_DIVI, OP_DIVI2:    c = C_DIVI;
        OP_ADDM, OP_ADDM2:    c = C_ADDM;
        OP_SUBM:              c = C_SUBM;
        OP_MULM:              c = C_MULM;
        OP_DIVM:              c = C_DIVM;
        OP_CMPII:             c = C_CMPII;
        OP_CMPVI:             c = C_CMPVI;
        OP_CMPAI:             c = C_CMPAI;
        OP_CMPAV:             c = C_CMPAV;
        OP_JNE:               c = C_JNE;
        OP_JMP:               c = C_JMP;
        OP_MOVIND:            c = C_MOVIND;
        OP_STIND:             c = C_STIND;
        OP_PRV:               c = C_PRV;
        OP_PRS:               c = C_PRS;
        OP_INP:               c = C_INP;
        OP_EXIT:              c = C_EXIT;
        OP_CALL:              c = C_CALL;
        OP_RET:               c = C_RET;
        default:              c = C_ILL;
      endcase
    end
    return c;
  endfunction

endpackage

// File: rtl/acb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module acb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/acb_div.sv
// Iterative signed 32-bit divider, one quotient bit a cycle, truncating.
// No package dependencies.
module acb_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic [31:0] q_r, q_nxt;
  logic [31:0] b_r, b_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] shifted;

  always_comb begin
    q_nxt    = q_r;
    b_nxt    = b_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[31:0], q_r[31]};
    if (start) begin
      neg_nxt  = dividend[31] ^ divisor[31];
      q_nxt    = dividend[31] ? (32'd0 - dividend) : dividend;
      b_nxt    = divisor[31] ? (32'd0 - divisor) : divisor;
      rem_nxt  = 33'd0;
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (shifted >= {1'b0, b_r}) begin
        rem_nxt = shifted - {1'b0, b_r};
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt   = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    b_r   <= b_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? (32'd0 - q_r) : q_r;

endmodule

// File: rtl/acb_datapath.sv
// Datapath: word memory, accumulator, pc, flags, return stack, ALU, divider
// and result registers. Uses acb_pkg, acb_ram and acb_div.
module acb_datapath
  import acb_pkg::*;
#(
  parameter int MEM_WORDS     = 65536,
  parameter int STACK_ENTRIES = 5
) (
  input  logic         clk,
  input  logic         rst_n,
  input  dp_cmd_t      cmd,
  output dp_stat_t     stat,
  input  logic [2:0]   in_cmd,
  input  logic [15:0]  in_address,
  input  logic [31:0]  in_data,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_wdata,
  output logic [31:0]  out_read_data,
  output logic [3:0]   out_status,
  output logic [15:0]  out_trap_address,
  output logic [15:0]  out_program_counter,
  output logic [31:0]  out_accumulator_out
);

  localparam int AW  = $clog2(MEM_WORDS);
  localparam int DW  = $clog2(STACK_ENTRIES + 1);
  localparam int SIW = $clog2(STACK_ENTRIES);

  // Reduce a 16-bit address modulo MEM_WORDS; quotient is below 256.
  function automatic logic [AW-1:0] wrap(input logic [15:0] x);
    logic [24:0] v;
    v = {9'd0, x};
    for (int k = 7; k >= 0; k--) begin
      if (v >= (25'(MEM_WORDS) << k)) begin
        v = v - (25'(MEM_WORDS) << k);
      end
    end
    return v[AW-1:0];
  endfunction

  logic [2:0]    cmd_r;
  logic [15:0]   inaddr_r;
  logic [31:0]   indata_r;
  logic [31:0]   op_r, o1_r, o2_r, t_r, r_r, acc_r, rdata_r;
  logic [AW-1:0] pc_r, tgt_r, trap_r, scan_r, cnt_r;
  logic          eq_r, gt_r, lt_r, pend_r;
  logic [AW-1:0] stk_r [STACK_ENTRIES];
  logic [DW-1:0] dep_r, dep_m1;
  logic [15:0]   base_r, start_r;

  logic [AW-1:0] a_in, a_pc1, a_pc2, a_pc3, va1, va2, vat, a_jt, a_start, a_scann;
  logic [AW-1:0] rd_addr, wr_addr, pc_new;
  logic [31:0]   wdata, x, y, alu_res, mem_rdata, div_q;
  logic          o1_pos, div_done;

  assign a_in    = wrap(inaddr_r);
  assign a_pc1   = wrap(16'(pc_r) + 16'd1);
  assign a_pc2   = wrap(16'(pc_r) + 16'd2);
  assign a_pc3   = wrap(16'(pc_r) + 16'd3);
  assign va1     = wrap(base_r + o1_r[15:0]);
  assign va2     = wrap(base_r + o2_r[15:0]);
  assign vat     = wrap(base_r + t_r[15:0]);
  assign o1_pos  = !o1_r[31] && (o1_r != 32'd0);
  assign a_jt    = wrap(16'(pc_r) + o1_r[15:0] + {15'd0, o1_pos});
  assign a_start = wrap(start_r);
  assign a_scann = wrap(16'(scan_r) + 16'd1);
  assign dep_m1  = dep_r - DW'(1);

  function automatic logic [AW-1:0] pick(input asel_t s, input logic [AW-1:0] ain,
      input logic [AW-1:0] pc, input logic [AW-1:0] p1, input logic [AW-1:0] p2,
      input logic [AW-1:0] v1, input logic [AW-1:0] v2, input logic [AW-1:0] vt,
      input logic [AW-1:0] tg, input logic [AW-1:0] sc);
    logic [AW-1:0] a;
    case (s)
      A_IN:    a = ain;
      A_PC:    a = pc;
      A_PC1:   a = p1;
      A_PC2:   a = p2;
      A_VO1:   a = v1;
      A_VO2:   a = v2;
      A_VT:    a = vt;
      A_TGT:   a = tg;
      A_SCAN:  a = sc;
      default: a = pc;
    endcase
    return a;
  endfunction

  assign rd_addr = pick(cmd.rd_sel, a_in, pc_r, a_pc1, a_pc2, va1, va2, vat, tgt_r, scan_r);
  assign wr_addr = pick(cmd.wr_sel, a_in, pc_r, a_pc1, a_pc2, va1, va2, vat, tgt_r, scan_r);

  always_comb begin
    case (cmd.wd_sel)
      W_IN:    wdata = indata_r;
      W_ACC:   wdata = acc_r;
      W_T:     wdata = t_r;
      W_O2:    wdata = o2_r;
      W_R:     wdata = r_r;
      default: wdata = r_r;
    endcase
  end

  acb_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_mem (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (wr_addr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (mem_rdata)
  );

  always_comb begin
    case (cmd.x_sel)
      X_ACC:   x = acc_r;
      X_T:     x = t_r;
      X_O1:    x = o1_r;
      default: x = acc_r;
    endcase
    case (cmd.y_sel)
      Y_O1:    y = o1_r;
      Y_O2:    y = o2_r;
      Y_T:     y = t_r;
      Y_ACC:   y = acc_r;
      default: y = o1_r;
    endcase
    case (cmd.alu_op)
      OP_ADD:  alu_res = x + y;
      OP_SUB:  alu_res = x - y;
      OP_MUL:  alu_res = 32'(x * y);
      OP_PASS: alu_res = y;
      OP_DIV:  alu_res = div_q;
      default: alu_res = y;
    endcase
  end

  acb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (x),
    .divisor  (y),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    case (cmd.pc_sel)
      PC_ADV1:  pc_new = a_pc1;
      PC_ADV2:  pc_new = a_pc2;
      PC_ADV3:  pc_new = a_pc3;
      PC_JT:    pc_new = a_jt;
      PC_START: pc_new = a_start;
      PC_POP:   pc_new = stk_r[dep_m1[SIW-1:0]];
      PC_SCANN: pc_new = a_scann;
      PC_TRAP:  pc_new = trap_r;
      default:  pc_new = pc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= 32'd0;
      pc_r    <= '0;
      eq_r    <= 1'b0;
      gt_r    <= 1'b0;
      lt_r    <= 1'b0;
      dep_r   <= '0;
      pend_r  <= 1'b0;
      tgt_r   <= '0;
      base_r  <= 16'd0;
      start_r <= 16'd0;
    end else begin
      if (cfg_we && cfg_index == REG_DATA_BASE) base_r <= cfg_wdata;
      if (cfg_we && cfg_index == REG_START) start_r <= cfg_wdata;
      if (cmd.acc_ld) acc_r <= cmd.acc_one ? 32'd1 : r_r;
      if (cmd.pc_ld) pc_r <= pc_new;
      if (cmd.cmp_ld) begin
        eq_r <= (x == y);
        gt_r <= ($signed(x) > $signed(y));
        lt_r <= ($signed(x) < $signed(y));
      end
      if (cmd.clr_depth) begin
        dep_r <= '0;
      end else if (cmd.push) begin
        dep_r <= dep_r + DW'(1);
      end else if (cmd.pop) begin
        dep_r <= dep_m1;
      end
      if (cmd.pend_set) begin
        pend_r <= 1'b1;
        tgt_r  <= va1;
      end else if (cmd.pend_clr) begin
        pend_r <= 1'b0;
      end
    end
    if (cmd.push) stk_r[dep_r[SIW-1:0]] <= a_pc2;
    if (cmd.in_ld) begin
      cmd_r    <= in_cmd;
      inaddr_r <= in_address;
      indata_r <= in_data;
      trap_r   <= '0;
      rdata_r  <= 32'd0;
    end
    if (cmd.op_ld) op_r <= mem_rdata;
    if (cmd.o1_ld) o1_r <= mem_rdata;
    if (cmd.o2_ld) o2_r <= mem_rdata;
    if (cmd.t_ld) t_r <= mem_rdata;
    if (cmd.rdata_ld) rdata_r <= mem_rdata;
    if (cmd.r_ld) r_r <= alu_res;
    if (cmd.tr_ld) trap_r <= (cmd.tr_sel == TR_PC1) ? a_pc1 : va1;
    if (cmd.scan_init) begin
      scan_r <= a_pc1;
      cnt_r  <= '0;
    end else if (cmd.scan_step) begin
      scan_r <= a_scann;
      cnt_r  <= cnt_r + AW'(1);
    end
    if (cmd.res_ld) begin
      out_read_data       <= rdata_r;
      out_status          <= cmd.res_status;
      out_trap_address    <= 16'(trap_r);
      out_program_counter <= 16'(pc_r);
      out_accumulator_out <= acc_r;
    end
  end

  assign stat.cmd         = cmd_r;
  assign stat.cls         = op_class(op_r);
  assign stat.pend        = pend_r;
  assign stat.acc_zero    = (acc_r == 32'd0);
  assign stat.o1_zero     = (o1_r == 32'd0);
  assign stat.t_zero      = (t_r == 32'd0);
  assign stat.eq          = eq_r;
  assign stat.gt          = gt_r;
  assign stat.lt          = lt_r;
  assign stat.stack_full  = (dep_r >= DW'(STACK_ENTRIES - 1));
  assign stat.stack_empty = (dep_r == '0);
  assign stat.div_done    = div_done;
  assign stat.mem_zero    = (mem_rdata == 32'd0);
  assign stat.scan_last   = (cnt_r == AW'(MEM_WORDS - 1));

endmodule

// File: rtl/acb_ctrl.sv
// Controller: sequences fetch, operand reads, execution and result hand-off.
// Uses acb_pkg; drives the datapath by dp_cmd_t and reads dp_stat_t.
module acb_ctrl
  import acb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_CMD, S_RDW, S_F1, S_F2, S_F3, S_DEC, S_MRD, S_EX2,
    S_DIVW, S_ACCW, S_MEMW, S_SRD, S_SCK, S_DONE
  } state_t;

  state_t  state_r, state_nxt;
  status_t st_r, st_nxt;
  logic    ind_r, ind_nxt;
  logic    out_valid_r, out_valid_nxt;
  pcsel_t  adv;

  always_comb begin
    case (stat.cls)
      C_MOVV, C_MOVI, C_CMPII, C_CMPVI, C_MOVIND: adv = PC_ADV3;
      C_TEQ, C_TGT, C_TLT, C_EXIT:                adv = PC_ADV1;
      default:                                    adv = PC_ADV2;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.res_status = st_r;
    state_nxt     = state_r;
    st_nxt        = st_r;
    ind_nxt       = ind_r;
    out_valid_nxt = out_valid_r & out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.in_ld = 1'b1;
          st_nxt    = ST_OK;
          ind_nxt   = 1'b0;
          state_nxt = S_CMD;
        end
      end
      S_CMD: begin
        state_nxt = S_DONE;
        case (stat.cmd)
          CMD_WRITE: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = A_IN;
            cmd.wd_sel = W_IN;
          end
          CMD_READ: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = A_IN;
            state_nxt  = S_RDW;
          end
          CMD_EXEC: begin
            if (stat.pend) begin
              st_nxt = ST_WAITING;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = A_PC;
              state_nxt  = S_F1;
            end
          end
          CMD_INPUT: begin
            if (stat.pend) begin
              cmd.wr_en    = 1'b1;
              cmd.wr_sel   = A_TGT;
              cmd.wd_sel   = W_IN;
              cmd.pend_clr = 1'b1;
            end
          end
          CMD_RESTART: begin
            cmd.pc_ld     = 1'b1;
            cmd.pc_sel    = PC_START;
            cmd.clr_depth = 1'b1;
            cmd.pend_clr  = 1'b1;
          end
          default: ;
        endcase
      end
      S_RDW: begin
        cmd.rdata_ld = 1'b1;
        state_nxt    = S_DONE;
      end
      S_F1: begin
        cmd.op_ld  = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = A_PC1;
        state_nxt  = S_F2;
      end
      S_F2: begin
        cmd.o1_ld  = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = A_PC2;
        state_nxt  = S_F3;
      end
      S_F3: begin
        cmd.o2_ld = 1'b1;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        state_nxt  = S_DONE;
        cmd.pc_sel = adv;
        case (stat.cls)
          C_LOAD, C_ADDV, C_SUBV, C_MULV, C_DIVV, C_ADDM, C_SUBM, C_MULM,
          C_CMPVI, C_CMPAV, C_STIND: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = A_VO1;
            state_nxt  = S_MRD;
          end
          C_MOVV, C_MOVIND: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = A_VO2;
            state_nxt  = S_MRD;
          end
          C_DIVM: begin
            if (stat.acc_zero) begin
              st_nxt = ST_DIVZERO;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = A_VO1;
              state_nxt  = S_MRD;
            end
          end
          C_LDI: begin
            cmd.alu_op = OP_PASS;
            cmd.y_sel  = Y_O1;
            cmd.r_ld   = 1'b1;
            state_nxt  = S_ACCW;
          end
          C_ADDI, C_SUBI, C_MULI: begin
            cmd.x_sel  = X_ACC;
            cmd.y_sel  = Y_O1;
            cmd.alu_op = (stat.cls == C_ADDI) ? OP_ADD :
                         (stat.cls == C_SUBI) ? OP_SUB : OP_MUL;
            cmd.r_ld   = 1'b1;
            state_nxt  = S_ACCW;
          end
          C_DIVI: begin
            if (stat.o1_zero) begin
              st_nxt = ST_DIVZERO;
            end else begin
              cmd.x_sel     = X_ACC;
              cmd.y_sel     = Y_O1;
              cmd.div_start = 1'b1;
              state_nxt     = S_DIVW;
            end
          end
          C_TEQ, C_TGT, C_TLT: begin
            cmd.acc_one = 1'b1;
            cmd.acc_ld  = (stat.cls == C_TEQ) ? stat.eq :
                          (stat.cls == C_TGT) ? stat.gt : stat.lt;
            cmd.pc_ld   = 1'b1;
          end
          C_STORE: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = A_VO1;
            cmd.wd_sel = W_ACC;
            cmd.pc_ld  = 1'b1;
          end
          C_MOVI: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = A_VO1;
            cmd.wd_sel = W_O2;
            cmd.pc_ld  = 1'b1;
          end
          C_CMPII, C_CMPAI: begin
            cmd.x_sel  = (stat.cls == C_CMPII) ? X_O1 : X_ACC;
            cmd.y_sel  = (stat.cls == C_CMPII) ? Y_O2 : Y_O1;
            cmd.cmp_ld = 1'b1;
            cmd.pc_ld  = 1'b1;
          end
          C_JNE: begin
            cmd.pc_ld = 1'b1;
            if (!stat.eq) cmd.pc_sel = PC_JT;
          end
          C_JMP: begin
            cmd.pc_ld  = 1'b1;
            cmd.pc_sel = PC_JT;
          end
          C_PRV: begin
            cmd.tr_ld  = 1'b1;
            cmd.tr_sel = TR_VO1;
            cmd.pc_ld  = 1'b1;
            st_nxt     = ST_PRINTVAL;
          end
          C_PRS: begin
            cmd.tr_ld     = 1'b1;
            cmd.tr_sel    = TR_PC1;
            cmd.scan_init = 1'b1;
            st_nxt        = ST_PRINTSTR;
            state_nxt     = S_SRD;
          end
          C_INP: begin
            cmd.tr_ld    = 1'b1;
            cmd.tr_sel   = TR_VO1;
            cmd.pend_set = 1'b1;
            cmd.pc_ld    = 1'b1;
            st_nxt       = ST_INPUTREQ;
          end
          C_EXIT: begin
            cmd.pc_ld = 1'b1;
            st_nxt    = ST_EXIT;
          end
          C_CALL: begin
            if (stat.stack_full) begin
              st_nxt = ST_OVERFLOW;
            end else begin
              cmd.push   = 1'b1;
              cmd.pc_ld  = 1'b1;
              cmd.pc_sel = PC_JT;
            end
          end
          C_RET: begin
            if (stat.stack_empty) begin
              st_nxt = ST_UNDERFLOW;
            end else begin
              cmd.pop    = 1'b1;
              cmd.pc_ld  = 1'b1;
              cmd.pc_sel = PC_POP;
            end
          end
          default: st_nxt = ST_ILLEGAL;
        endcase
      end
      S_MRD: begin
        cmd.t_ld  = 1'b1;
        state_nxt = S_EX2;
      end
      S_EX2: begin
        state_nxt  = S_DONE;
        cmd.pc_sel = adv;
        case (stat.cls)
          C_LOAD: begin
            cmd.alu_op = OP_PASS;
            cmd.y_sel  = Y_T;
            cmd.r_ld   = 1'b1;
            state_nxt  = S_ACCW;
          end
          C_ADDV, C_SUBV, C_MULV: begin
            cmd.x_sel  = X_ACC;
            cmd.y_sel  = Y_T;
            cmd.alu_op = (stat.cls == C_ADDV) ? OP_ADD :
                         (stat.cls == C_SUBV) ? OP_SUB : OP_MUL;
            cmd.r_ld   = 1'b1;
            state_nxt  = S_ACCW;
          end
          C_ADDM, C_SUBM, C_MULM: begin
            cmd.x_sel  = X_T;
            cmd.y_sel  = Y_ACC;
            cmd.alu_op = (stat.cls == C_ADDM) ? OP_ADD :
                         (stat.cls == C_SUBM) ? OP_SUB : OP_MUL;
            cmd.r_ld   = 1'b1;
            state_nxt  = S_MEMW;
          end
          C_DIVV: begin
            if (stat.t_zero) begin
              st_nxt = ST_DIVZERO;
            end else begin
              cmd.x_sel     = X_ACC;
              cmd.y_sel     = Y_T;
              cmd.div_start = 1'b1;
              state_nxt     = S_DIVW;
            end
          end
          C_DIVM: begin
            cmd.x_sel     = X_T;
            cmd.y_sel     = Y_ACC;
            cmd.div_start = 1'b1;
            state_nxt     = S_DIVW;
          end
          C_MOVV: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = A_VO1;
            cmd.wd_sel = W_T;
            cmd.pc_ld  = 1'b1;
          end
          C_CMPVI, C_CMPAV: begin
            cmd.x_sel  = (stat.cls == C_CMPVI) ? X_T : X_ACC;
            cmd.y_sel  = (stat.cls == C_CMPVI) ? Y_O2 : Y_T;
            cmd.cmp_ld = 1'b1;
            cmd.pc_ld  = 1'b1;
          end
          C_MOVIND: begin
            if (!ind_r) begin
              // second hop: fetch the word the pointer names
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = A_VT;
              ind_nxt    = 1'b1;
              state_nxt  = S_MRD;
            end else begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = A_VO1;
              cmd.wd_sel = W_T;
              cmd.pc_ld  = 1'b1;
            end
          end
          C_STIND: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = A_VT;
            cmd.wd_sel = W_ACC;
            cmd.pc_ld  = 1'b1;
          end
          default: st_nxt = ST_ILLEGAL;
        endcase
      end
      S_DIVW: begin
        cmd.alu_op = OP_DIV;
        if (stat.div_done) begin
          cmd.r_ld  = 1'b1;
          state_nxt = (stat.cls == C_DIVM) ? S_MEMW : S_ACCW;
        end
      end
      S_ACCW: begin
        cmd.acc_ld = 1'b1;
        cmd.pc_ld  = 1'b1;
        cmd.pc_sel = adv;
        state_nxt  = S_DONE;
      end
      S_MEMW: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = A_VO1;
        cmd.wd_sel = W_R;
        cmd.pc_ld  = 1'b1;
        cmd.pc_sel = adv;
        state_nxt  = S_DONE;
      end
      S_SRD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = A_SCAN;
        state_nxt  = S_SCK;
      end
      S_SCK: begin
        if (stat.mem_zero) begin
          cmd.pc_ld  = 1'b1;
          cmd.pc_sel = PC_SCANN;
          state_nxt  = S_DONE;
        end else if (stat.scan_last) begin
          // no terminator anywhere: back to the string start
          cmd.pc_ld  = 1'b1;
          cmd.pc_sel = PC_TRAP;
          state_nxt  = S_DONE;
        end else begin
          cmd.scan_step = 1'b1;
          state_nxt     = S_SRD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.res_ld    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      st_r        <= ST_OK;
      ind_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      st_r        <= st_nxt;
      ind_r       <= ind_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: rtl/accumulator_bytecode_core.sv
// Accumulator bytecode core: one item at a time, taken only when idle.
// An executed instruction fetches three words, then makes up to two more memory
// reads; a divide waits for 32 quotient bits from the shared divider, and a
// string print scans memory word by word for a zero terminator. A stalled
// result holds back the next result.
// Synchronous active-low reset clears accumulator, pc, flags, stack depth and
// pending input; memory contents are not cleared.
module accumulator_bytecode_core
  import acb_pkg::*;
#(
  parameter int MEM_WORDS     = 65536,
  parameter int STACK_ENTRIES = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [15:0] in_address,
  input  logic [31:0] in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_read_data,
  output logic [3:0]  out_status,
  output logic [15:0] out_trap_address,
  output logic [15:0] out_program_counter,
  output logic [31:0] out_accumulator_out,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  acb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  acb_datapath #(
    .MEM_WORDS     (MEM_WORDS),
    .STACK_ENTRIES (STACK_ENTRIES)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_cmd              (in_cmd),
    .in_address          (in_address),
    .in_data             (in_data),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .out_read_data       (out_read_data),
    .out_status          (out_status),
    .out_trap_address    (out_trap_address),
    .out_program_counter (out_program_counter),
    .out_accumulator_out (out_accumulator_out)
  );

endmodule

// File: rtl/acb_checker.sv
// Port-level checks for accumulator_bytecode_core, bound to the top level.
// Depends on acb_pkg for status codes and on the top-level ports.
module acb_checker
  import acb_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_read_data,
  input logic [3:0]  out_status,
  input logic [15:0] out_program_counter,
  input logic [31:0] out_accumulator_out
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // hold a stalled item
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_stall |=> out_valid && $stable(out_read_data) &&
      $stable(out_status) && $stable(out_program_counter) &&
      $stable(out_accumulator_out))
    else $error("stalled result changed");

  // one item at a time: an accepted item blocks the next cycle
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
      in_valid && !in_stall |=> in_stall)
    else $error("item taken while busy");

  // only a read returns data, so nonzero read data must come with an ok status
  a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_read_data != 32'd0 |-> out_status == ST_OK)
    else $error("read data with non-ok status");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |-> out_status <= ST_WAITING)
    else $error("status out of range");

endmodule

bind accumulator_bytecode_core acb_checker u_acb_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_read_data       (out_read_data),
  .out_status          (out_status),
  .out_program_counter (out_program_counter),
  .out_accumulator_out (out_accumulator_out)
);
